### rtl/lsrf_pkg.sv
// Shared types, constants and saturating Q32.32 helpers of the row formulator.
`default_nettype none
package lsrf_pkg;

   // default coordinate fraction width (Q16.16)
   localparam int COORD_FRAC_BITS_DEF = 16;
   // cycles through one saturating multiplier
   localparam int MUL_LAT = 4;
   // cycles through the reciprocal unit, one quotient bit each
   localparam int RECIP_LAT = 64;

   localparam logic [63:0] FX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FX_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] FX_ONE = 64'h0000_0001_0000_0000;

   typedef enum logic [1:0] {
      SHAPE_LINE    = 2'd0,
      SHAPE_CIRCLE  = 2'd1,
      SHAPE_ELLIPSE = 2'd2
   } shape_type;

   typedef enum logic [2:0] {
      REG_SHAPE  = 3'd0,
      REG_P0     = 3'd1,
      REG_P1     = 3'd2,
      REG_MAJOR  = 3'd3,
      REG_MINOR  = 3'd4,
      REG_SINE   = 3'd5,
      REG_COSINE = 3'd6
   } reg_index_type;

   // Q32.32 value with its accumulated saturation flag
   typedef struct packed {
      logic        sat;
      logic [63:0] val;
   } fx_type;

   localparam int FX_W = $bits(fx_type);

   function automatic fx_type fx_add(fx_type a, fx_type b);
      logic [63:0] r;
      logic        ovf;
      fx_type      o;
      r     = a.val + b.val;
      ovf   = (a.val[63] == b.val[63]) && (r[63] != a.val[63]);
      o.sat = a.sat | b.sat | ovf;
      o.val = ovf ? (a.val[63] ? FX_MIN : FX_MAX) : r;
      return o;
   endfunction

   function automatic fx_type fx_sub(fx_type a, fx_type b);
      logic [63:0] r;
      logic        ovf;
      fx_type      o;
      r     = a.val - b.val;
      ovf   = (a.val[63] != b.val[63]) && (r[63] != a.val[63]);
      o.sat = a.sat | b.sat | ovf;
      o.val = ovf ? (a.val[63] ? FX_MIN : FX_MAX) : r;
      return o;
   endfunction

   function automatic fx_type fx_dbl(fx_type a);
      return fx_add(a, a);
   endfunction

   // zero minus a, saturating
   function automatic fx_type fx_neg(fx_type a);
      return fx_sub('0, a);
   endfunction

endpackage
`default_nettype wire

### rtl/least_squares_row_formulator_top.sv
// Top level of the least-squares row formulator: stream ports, registers, datapath.
//
// One point (x, y) enters on the req_ stream; one linearized row leaves on the
// rsp_ stream for it, in order. The csr_ port holds the shape mode and the
// provisional parameters; write it only while no point is in flight.
// The pipeline depth is set by the chain of saturating multipliers (four in
// a row for the ellipse weight) and the 64-stage reciprocal divider.
// Throughput: one point per cycle while the receiver takes rows.
// All stages move together; when a row waits on rsp_ with rsp_tready low, the
// whole pipeline holds and req_tready drops in the same cycle, so nothing is
// lost or repeated. Reset empties the pipeline and loads the register
// defaults (line mode, zero parameters, cosine 1.0, sine 0).
// Rows carry Q32.32 values; rsp_tuser flags saturation or a tiny weight
// denominator, and rsp_tlast copies req_tlast.
`default_nettype none
module least_squares_row_formulator_top import lsrf_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // [31:0] point_x, [63:32] point_y
   input  wire logic [63:0]  req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [63:0] design_0 .. [319:256] design_4, [382:320] obs_weight,
   // [446:383] misclosure, [510:447] cond_x, [574:511] cond_y, [575] zero
   output logic [575:0]      rsp_tdata,
   // [0] saturated
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CoordShift = 32 - COORD_FRAC_BITS;
   localparam int M       = MUL_LAT;
   localparam int T_SQ    = 1 + M;
   localparam int T_UV    = T_SQ + 1;
   localparam int T_P2    = T_UV + M;
   localparam int T_PA    = T_P2 + 1;
   localparam int T_P3    = T_P2 + M;
   localparam int T_D     = T_PA + M;
   localparam int T_SQ2   = T_P3 + 2 + M;
   localparam int T_DEN   = T_SQ2 + 1;
   localparam int T_FIN   = T_DEN + RECIP_LAT;

   // configuration registers
   logic [1:0]  shape_ff;
   logic [31:0] p0_ff, p1_ff, major_ff, minor_ff, sine_ff, cosine_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // pipeline control
   logic              adv;
   logic [T_FIN:0]    vld_ff;
   logic [31:0]       in_x_ff, in_y_ff;
   logic              in_last_ff;

   fx_type x_fx, y_fx, p0_fx, p1_fx, a_fx, b_fx, sn_fx, cs_fx, one_fx;
   fx_type dx_ff, dy_ff, cd0_ff, cd1_ff, cd2_ff, cx_ff, cy_ff;
   fx_type xp_w, ls_ff, lmis_ff, y_d;
   fx_type aa_w, bb_w, a5_w, a6_w, b6_w, a10_w, b10_w, ab_w, ab15_w;
   fx_type dxs_w, dys_w, csum_ff, cmis_ff, cden_ff, cden_d;
   fx_type dycs_w, dxsn_w, dxcs_w, dysn_w, u_ff, v_ff, du_ff, v1_ff;
   fx_type au_w, bv_w, uu_w, vv_w, uv2_w;
   fx_type nub_ff, va_ff, bma_ff, a2_ff, b2_ff;
   fx_type aus_w, bvc_w, bvs_w, auc_w, auu_w, bvv_w;
   fx_type d2_w, d3_w, d4_w;
   fx_type ed0a_ff, es1_ff, es2_ff, ed0_ff, ed1_ff, em2_ff, em_ff;
   fx_type sq0_w, sq1_w, eden_ff, den_w;
   logic [62:0] wgt_w;
   logic        wsat_w;

   // aligned at the final stage
   logic [31:0] xf_raw;
   logic        last_f;
   fx_type lmis_f, cd0_f, cd1_f, cd2_f, cx_f, cy_f, cmis_f;
   fx_type ed0_f, ed1_f, d2_f, d3_f, d4_f, em_f;

   // output stage
   logic [63:0] o_d0, o_d1, o_d2, o_d3, o_d4, o_mis, o_cx, o_cy;
   logic [62:0] o_w;
   logic        o_sat;
   logic [575:0] rsp_data_ff;
   logic         rsp_sat_ff, rsp_last_ff, rsp_valid_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= SHAPE_LINE;
         p0_ff     <= '0;
         p1_ff     <= '0;
         major_ff  <= '0;
         minor_ff  <= '0;
         sine_ff   <= '0;
         cosine_ff <= 32'h4000_0000;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SHAPE:  shape_ff  <= csr_pwdata[1:0];
            REG_P0:     p0_ff     <= csr_pwdata;
            REG_P1:     p1_ff     <= csr_pwdata;
            REG_MAJOR:  major_ff  <= csr_pwdata;
            REG_MINOR:  minor_ff  <= csr_pwdata;
            REG_SINE:   sine_ff   <= csr_pwdata;
            REG_COSINE: cosine_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SHAPE:  csr_prdata = {30'b0, shape_ff};
         REG_P0:     csr_prdata = p0_ff;
         REG_P1:     csr_prdata = p1_ff;
         REG_MAJOR:  csr_prdata = major_ff;
         REG_MINOR:  csr_prdata = minor_ff;
         REG_SINE:   csr_prdata = sine_ff;
         REG_COSINE: csr_prdata = cosine_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   assign adv        = ~rsp_valid_ff | rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[T_FIN-1:0], req_tvalid};
         rsp_valid_ff <= vld_ff[T_FIN];
      end
   end

   // capture the point
   always_ff @(posedge clock) begin
      if (adv) begin
         in_x_ff    <= req_tdata[31:0];
         in_y_ff    <= req_tdata[63:32];
         in_last_ff <= req_tlast;
      end
   end

   // widen coordinates to Q32.32, rotation from Q2.30
   assign x_fx   = '{sat: 1'b0, val: ({{32{in_x_ff[31]}}, in_x_ff} << CoordShift)};
   assign y_fx   = '{sat: 1'b0, val: ({{32{in_y_ff[31]}}, in_y_ff} << CoordShift)};
   assign p0_fx  = '{sat: 1'b0, val: ({{32{p0_ff[31]}}, p0_ff} << CoordShift)};
   assign p1_fx  = '{sat: 1'b0, val: ({{32{p1_ff[31]}}, p1_ff} << CoordShift)};
   assign a_fx   = '{sat: 1'b0, val: ({{32{major_ff[31]}}, major_ff} << CoordShift)};
   assign b_fx   = '{sat: 1'b0, val: ({{32{minor_ff[31]}}, minor_ff} << CoordShift)};
   assign sn_fx  = '{sat: 1'b0, val: {{30{sine_ff[31]}}, sine_ff, 2'b00}};
   assign cs_fx  = '{sat: 1'b0, val: {{30{cosine_ff[31]}}, cosine_ff, 2'b00}};
   assign one_fx = '{sat: 1'b0, val: FX_ONE};

   // ---------------- line ----------------
   lsrf_smul u_xp (.clock, .en(adv), .a_i(x_fx), .b_i(p0_fx), .p_o(xp_w));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(M + 1)) u_yd (
      .clock, .en(adv), .d_i(y_fx), .q_o(y_d));

   always_ff @(posedge clock) begin
      if (adv) begin
         ls_ff   <= fx_add(xp_w, p1_fx);
         lmis_ff <= fx_sub(y_d, ls_ff);
      end
   end

   // ---------------- offsets and circle terms ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= fx_sub(x_fx, p0_fx);
         dy_ff  <= fx_sub(y_fx, p1_fx);
         cd0_ff <= fx_neg(fx_dbl(dx_ff));
         cd1_ff <= fx_neg(fx_dbl(dy_ff));
         cd2_ff <= fx_neg(fx_dbl(a_fx));
         cx_ff  <= fx_dbl(dx_ff);
         cy_ff  <= fx_dbl(dy_ff);
      end
   end

   lsrf_smul u_aa  (.clock, .en(adv), .a_i(a_fx),  .b_i(a_fx),  .p_o(aa_w));
   lsrf_smul u_bb  (.clock, .en(adv), .a_i(b_fx),  .b_i(b_fx),  .p_o(bb_w));
   lsrf_smul u_dxs (.clock, .en(adv), .a_i(dx_ff), .b_i(dx_ff), .p_o(dxs_w));
   lsrf_smul u_dys (.clock, .en(adv), .a_i(dy_ff), .b_i(dy_ff), .p_o(dys_w));

   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_SQ - M)) u_a5 (
      .clock, .en(adv), .d_i(aa_w), .q_o(a5_w));

   always_ff @(posedge clock) begin
      if (adv) begin
         csum_ff <= fx_add(dxs_w, dys_w);
         cmis_ff <= fx_sub(fx_sub(a5_w, dxs_w), dys_w);
         cden_ff <= fx_dbl(fx_dbl(csum_ff));
      end
   end

   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_DEN - (T_SQ + 2))) u_cden (
      .clock, .en(adv), .d_i(cden_ff), .q_o(cden_d));

   // ---------------- ellipse: rotated offsets ----------------
   lsrf_smul u_dycs (.clock, .en(adv), .a_i(dy_ff), .b_i(cs_fx), .p_o(dycs_w));
   lsrf_smul u_dxsn (.clock, .en(adv), .a_i(dx_ff), .b_i(sn_fx), .p_o(dxsn_w));
   lsrf_smul u_dxcs (.clock, .en(adv), .a_i(dx_ff), .b_i(cs_fx), .p_o(dxcs_w));
   lsrf_smul u_dysn (.clock, .en(adv), .a_i(dy_ff), .b_i(sn_fx), .p_o(dysn_w));

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff  <= fx_sub(dycs_w, dxsn_w);
         v_ff  <= fx_add(dxcs_w, dysn_w);
         du_ff <= fx_dbl(u_ff);
         v1_ff <= v_ff;
      end
   end

   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_UV - M)) u_a6 (
      .clock, .en(adv), .d_i(aa_w), .q_o(a6_w));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_UV - M)) u_b6 (
      .clock, .en(adv), .d_i(bb_w), .q_o(b6_w));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_P2 - M)) u_a10 (
      .clock, .en(adv), .d_i(aa_w), .q_o(a10_w));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_P2 - M)) u_b10 (
      .clock, .en(adv), .d_i(bb_w), .q_o(b10_w));

   // ---------------- ellipse: second product level ----------------
   lsrf_smul u_au  (.clock, .en(adv), .a_i(a6_w),  .b_i(u_ff),  .p_o(au_w));
   lsrf_smul u_bv  (.clock, .en(adv), .a_i(b6_w),  .b_i(v_ff),  .p_o(bv_w));
   lsrf_smul u_uu  (.clock, .en(adv), .a_i(u_ff),  .b_i(u_ff),  .p_o(uu_w));
   lsrf_smul u_vv  (.clock, .en(adv), .a_i(v_ff),  .b_i(v_ff),  .p_o(vv_w));
   lsrf_smul u_uv2 (.clock, .en(adv), .a_i(du_ff), .b_i(v1_ff), .p_o(uv2_w));
   lsrf_smul u_ab  (.clock, .en(adv), .a_i(aa_w),  .b_i(bb_w),  .p_o(ab_w));

   always_ff @(posedge clock) begin
      if (adv) begin
         nub_ff <= fx_sub(uu_w, b10_w);
         va_ff  <= fx_sub(vv_w, a10_w);
         bma_ff <= fx_sub(b10_w, a10_w);
         a2_ff  <= fx_dbl(a_fx);
         b2_ff  <= fx_dbl(b_fx);
      end
   end

   // ---------------- ellipse: third product level ----------------
   lsrf_smul u_aus (.clock, .en(adv), .a_i(au_w),   .b_i(sn_fx),  .p_o(aus_w));
   lsrf_smul u_bvc (.clock, .en(adv), .a_i(bv_w),   .b_i(cs_fx),  .p_o(bvc_w));
   lsrf_smul u_bvs (.clock, .en(adv), .a_i(bv_w),   .b_i(sn_fx),  .p_o(bvs_w));
   lsrf_smul u_auc (.clock, .en(adv), .a_i(au_w),   .b_i(cs_fx),  .p_o(auc_w));
   lsrf_smul u_auu (.clock, .en(adv), .a_i(a10_w),  .b_i(uu_w),   .p_o(auu_w));
   lsrf_smul u_bvv (.clock, .en(adv), .a_i(b10_w),  .b_i(vv_w),   .p_o(bvv_w));
   lsrf_smul u_d2  (.clock, .en(adv), .a_i(a2_ff),  .b_i(nub_ff), .p_o(d2_w));
   lsrf_smul u_d3  (.clock, .en(adv), .a_i(b2_ff),  .b_i(va_ff),  .p_o(d3_w));
   lsrf_smul u_d4  (.clock, .en(adv), .a_i(uv2_w),  .b_i(bma_ff), .p_o(d4_w));

   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_P3 + 1 - 2 * M)) u_abd (
      .clock, .en(adv), .d_i(ab_w), .q_o(ab15_w));

   // combine into design entries and misclosure
   always_ff @(posedge clock) begin
      if (adv) begin
         ed0a_ff <= fx_dbl(fx_sub(aus_w, bvc_w));
         es1_ff  <= fx_add(bvs_w, auc_w);
         es2_ff  <= fx_add(auu_w, bvv_w);
         ed0_ff  <= ed0a_ff;
         ed1_ff  <= fx_neg(fx_dbl(es1_ff));
         em2_ff  <= fx_sub(es2_ff, ab15_w);
         em_ff   <= fx_neg(em2_ff);
      end
   end

   lsrf_smul u_sq0 (.clock, .en(adv), .a_i(ed0_ff), .b_i(ed0_ff), .p_o(sq0_w));
   lsrf_smul u_sq1 (.clock, .en(adv), .a_i(ed1_ff), .b_i(ed1_ff), .p_o(sq1_w));

   always_ff @(posedge clock) begin
      if (adv) begin
         eden_ff <= fx_add(sq0_w, sq1_w);
      end
   end

   // ---------------- shared reciprocal ----------------
   assign den_w = (shape_ff == SHAPE_CIRCLE) ? cden_d : eden_ff;

   lsrf_recip u_recip (.clock, .en(adv), .den_i(den_w), .weight_o(wgt_w), .sat_o(wsat_w));

   // ---------------- alignment to the final stage ----------------
   lsrf_delay #(.WIDTH(33), .DEPTH(T_FIN)) u_xf (
      .clock, .en(adv), .d_i({in_last_ff, in_x_ff}), .q_o({last_f, xf_raw}));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_FIN - (M + 2))) u_lmf (
      .clock, .en(adv), .d_i(lmis_ff), .q_o(lmis_f));
   lsrf_delay #(.WIDTH(5 * FX_W), .DEPTH(T_FIN - 2)) u_cdf (
      .clock, .en(adv), .d_i({cd0_ff, cd1_ff, cd2_ff, cx_ff, cy_ff}),
      .q_o({cd0_f, cd1_f, cd2_f, cx_f, cy_f}));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_FIN - (T_SQ + 1))) u_cmf (
      .clock, .en(adv), .d_i(cmis_ff), .q_o(cmis_f));
   lsrf_delay #(.WIDTH(2 * FX_W), .DEPTH(T_FIN - (T_P3 + 2))) u_edf (
      .clock, .en(adv), .d_i({ed0_ff, ed1_ff}), .q_o({ed0_f, ed1_f}));
   lsrf_delay #(.WIDTH(3 * FX_W), .DEPTH(T_FIN - T_D)) u_ddf (
      .clock, .en(adv), .d_i({d2_w, d3_w, d4_w}), .q_o({d2_f, d3_f, d4_f}));
   lsrf_delay #(.WIDTH(FX_W), .DEPTH(T_FIN - (T_P3 + 3))) u_emf (
      .clock, .en(adv), .d_i(em_ff), .q_o(em_f));

   // ---------------- row select per shape ----------------
   always_comb begin
      o_d0  = '0;
      o_d1  = '0;
      o_d2  = '0;
      o_d3  = '0;
      o_d4  = '0;
      o_w   = '0;
      o_mis = '0;
      o_cx  = '0;
      o_cy  = '0;
      o_sat = 1'b0;
      unique case (shape_ff)
         SHAPE_LINE: begin
            o_d0  = {{32{xf_raw[31]}}, xf_raw} << CoordShift;
            o_d1  = one_fx.val;
            o_w   = one_fx.val[62:0];
            o_mis = lmis_f.val;
            o_sat = lmis_f.sat;
         end
         SHAPE_CIRCLE: begin
            o_d0  = cd0_f.val;
            o_d1  = cd1_f.val;
            o_d2  = cd2_f.val;
            o_w   = wgt_w;
            o_mis = cmis_f.val;
            o_cx  = cx_f.val;
            o_cy  = cy_f.val;
            o_sat = cd0_f.sat | cd1_f.sat | cd2_f.sat | cx_f.sat | cy_f.sat
                  | cmis_f.sat | wsat_w;
         end
         SHAPE_ELLIPSE: begin
            o_d0  = ed0_f.val;
            o_d1  = ed1_f.val;
            o_d2  = d2_f.val;
            o_d3  = d3_f.val;
            o_d4  = d4_f.val;
            o_w   = wgt_w;
            o_mis = em_f.val;
            o_sat = ed0_f.sat | ed1_f.sat | d2_f.sat | d3_f.sat | d4_f.sat
                  | em_f.sat | wsat_w;
         end
         default: ;
      endcase
   end

   // output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {1'b0, o_cy, o_cx, o_mis, o_w, o_d4, o_d3, o_d2, o_d1, o_d0};
         rsp_sat_ff  <= o_sat;
         rsp_last_ff <= last_f;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // ---------------- checks ----------------
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("pipeline valid bits moved during stall");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted item missing in first stage");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && vld_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### rtl/lsrf_delay.sv
// Stallable delay line that keeps operands aligned with the datapath.
`default_nettype none
module lsrf_delay import lsrf_pkg::*; #(
   parameter int WIDTH = FX_W,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] d_i,
   output logic      [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   // shift on every advance, hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q_o = pipe_ff[DEPTH-1];

endmodule
`default_nettype wire

### rtl/lsrf_smul.sv
// Four-stage saturating Q32.32 multiplier built from 32x32 partial products.
`default_nettype none
module lsrf_smul import lsrf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   en,
   input  wire fx_type a_i,
   input  wire fx_type b_i,
   output fx_type      p_o
);

   logic        neg1_ff, sat1_ff;
   logic [63:0] mx_ff, my_ff;
   logic        neg2_ff, sat2_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic        neg3_ff, sat3_ff, hovf_ff, frac_ff;
   logic [63:0] ms_ff;
   fx_type      p_ff;
   logic [33:0] mid_in;
   logic [63:0] hi_in;
   fx_type      p_in;

   // fold partial products into the Q32.32 window
   always_comb begin
      mid_in = {2'b0, p00_ff[63:32]} + {2'b0, p01_ff[31:0]} + {2'b0, p10_ff[31:0]};
      hi_in  = p11_ff + {32'b0, p01_ff[63:32]} + {32'b0, p10_ff[63:32]}
             + {62'b0, mid_in[33:32]};
   end

   // saturate and apply sign, flooring negative products
   always_comb begin
      p_in.sat = sat3_ff;
      if (hovf_ff) begin
         p_in.sat = 1'b1;
         p_in.val = neg3_ff ? FX_MIN : FX_MAX;
      end else if (!neg3_ff) begin
         p_in.sat = sat3_ff | ms_ff[63];
         p_in.val = ms_ff[63] ? FX_MAX : ms_ff;
      end else if (ms_ff[63]) begin
         p_in.sat = sat3_ff | (ms_ff != FX_MIN) | frac_ff;
         p_in.val = FX_MIN;
      end else begin
         p_in.val = ~ms_ff + {63'b0, ~frac_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= a_i.val[63] ^ b_i.val[63];
         sat1_ff <= a_i.sat | b_i.sat;
         mx_ff   <= a_i.val[63] ? (64'd0 - a_i.val) : a_i.val;
         my_ff   <= b_i.val[63] ? (64'd0 - b_i.val) : b_i.val;
         neg2_ff <= neg1_ff;
         sat2_ff <= sat1_ff;
         p00_ff  <= mx_ff[31:0] * my_ff[31:0];
         p01_ff  <= mx_ff[31:0] * my_ff[63:32];
         p10_ff  <= mx_ff[63:32] * my_ff[31:0];
         p11_ff  <= mx_ff[63:32] * my_ff[63:32];
         neg3_ff <= neg2_ff;
         sat3_ff <= sat2_ff;
         hovf_ff <= |hi_in[63:32];
         frac_ff <= |p00_ff[31:0];
         ms_ff   <= {hi_in[31:0], mid_in[31:0]};
         p_ff    <= p_in;
      end
   end

   assign p_o = p_ff;

endmodule
`default_nettype wire

### rtl/lsrf_recip.sv
// Pipelined restoring divider: floor(2^64 / den), one quotient bit per stage.
`default_nettype none
module lsrf_recip import lsrf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire fx_type      den_i,
   output logic [62:0]      weight_o,
   output logic             sat_o
);

   logic [63:0] rem_ff [RECIP_LAT];
   logic [62:0] dvs_ff [RECIP_LAT];
   logic [62:0] quo_ff [RECIP_LAT];
   logic        sml_ff [RECIP_LAT];
   logic        sat_ff [RECIP_LAT];
   logic [63:0] rem_in [RECIP_LAT];
   logic [62:0] dvs_in [RECIP_LAT];
   logic [62:0] quo_in [RECIP_LAT];
   logic        sml_in [RECIP_LAT];
   logic        sat_in [RECIP_LAT];
   logic        small_w;

   // a denominator of two LSBs or less saturates the weight
   assign small_w = ($signed(den_i.val) <= 64'sd2);

   // one trial subtract per stage
   always_comb begin
      logic [63:0] prem;
      logic [62:0] pquo;
      logic [64:0] two;
      logic [64:0] diff;
      for (int i = 0; i < RECIP_LAT; i++) begin
         if (i == 0) begin
            prem      = 64'd1;
            pquo      = '0;
            dvs_in[i] = den_i.val[62:0];
            sml_in[i] = small_w;
            sat_in[i] = den_i.sat;
         end else begin
            prem      = rem_ff[i-1];
            pquo      = quo_ff[i-1];
            dvs_in[i] = dvs_ff[i-1];
            sml_in[i] = sml_ff[i-1];
            sat_in[i] = sat_ff[i-1];
         end
         two       = {prem, 1'b0};
         diff      = two - {2'b0, dvs_in[i]};
         rem_in[i] = diff[64] ? two[63:0] : diff[63:0];
         quo_in[i] = {pquo[61:0], ~diff[64]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         dvs_ff <= dvs_in;
         quo_ff <= quo_in;
         sml_ff <= sml_in;
         sat_ff <= sat_in;
      end
   end

   assign weight_o = sml_ff[RECIP_LAT-1] ? {63{1'b1}} : quo_ff[RECIP_LAT-1];
   assign sat_o    = sat_ff[RECIP_LAT-1] | sml_ff[RECIP_LAT-1];

endmodule
`default_nettype wire
